>>> hdl/mbrc_pkg.sv
// Package for the Modbus RTU response checker: item codes, status codes,
// register indexes, frame limits and the byte-wide CRC-16 update.
// No dependencies.
`timescale 1ns / 1ps

package mbrc_pkg;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_ARM  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    // final status codes
    typedef enum logic [1:0] {
        ST_PROCESSED = 2'd0,
        ST_CORRUPTED = 2'd1,
        ST_EXCEPTION = 2'd2,
        ST_TIMEOUT   = 2'd3
    } status_t;

    // result word kinds
    localparam logic RES_WORD   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGISTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd4;

    // function codes
    localparam logic [6:0] OP_READ  = 7'h03;
    localparam logic [6:0] OP_WRITE = 7'h10;

    // frame limits
    localparam logic [8:0]  MAX_FRAME_BYTES = 9'd257;
    localparam logic [7:0]  MAX_READ_REGS   = 8'd125;
    localparam logic [8:0]  BYTE_CNT_MAX    = 9'h1FF;
    localparam logic [16:0] ELAPSED_MAX     = 17'h1FFFF;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // one byte through the reflected Modbus CRC-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/modbus_response_checker_core.sv
// Modbus RTU master response checker, top level: input stage, frame state,
// CRC and verdict logic, result register. Depends on mbrc_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   s_       | s_valid / s_ready      | s_kind, s_rx_byte, s_frame_end
//   m_       | m_valid / m_ready      | m_result_kind, m_reg_index,
//            |                        | m_reg_value, m_status, m_exception_code
//   cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle sustained while the result register is not stalled.
// A word is held in the input register, then one byte-wide CRC step and the
// checks update the frame state and load its result into the result register.
// A stalled result register holds the input register, and s_ready drops
// only when both are full. Synchronous reset clears all control state and
// restores the configuration defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module modbus_response_checker_core
    import mbrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [6:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic [1:0]  m_status,
    output logic [7:0]  m_exception_code,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [7:0]  slave_addr_reg;
    logic        req_mode_reg;
    logic [15:0] first_reg_reg;
    logic [6:0]  reg_count_reg;
    logic [15:0] timeout_reg;

    // input stage
    logic        in_valid_reg;
    kind_t       in_kind_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    // frame state
    logic        waiting_reg,  waiting_next;
    logic [8:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  dly0_reg,     dly0_next;
    logic [7:0]  dly1_reg,     dly1_next;
    logic [7:0]  hdr_reg  [6];
    logic [7:0]  hdr_next [6];
    logic [16:0] elapsed_reg,  elapsed_next;
    logic        too_long_reg, too_long_next;

    // result register
    logic        m_valid_reg,  m_valid_next;
    logic        res_kind_reg, res_kind_next;
    logic [6:0]  res_idx_reg,  res_idx_next;
    logic [15:0] res_val_reg,  res_val_next;
    status_t     res_st_reg,   res_st_next;
    logic [7:0]  res_code_reg, res_code_next;

    // per-item working values
    logic        advance;
    logic [8:0]  p;
    logic [9:0]  frame_len;
    logic [9:0]  min_read_len;
    logic [15:0] crc_upd;
    logic [8:0]  p_minus4;
    logic [7:0]  word_idx;
    logic [6:0]  opcode;
    status_t     verdict;
    logic [7:0]  verdict_code;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = res_kind_reg;
    assign m_reg_index      = res_idx_reg;
    assign m_reg_value      = res_val_reg;
    assign m_status         = res_st_reg;
    assign m_exception_code = res_code_reg;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= 8'd1;
            req_mode_reg   <= 1'b0;
            first_reg_reg  <= 16'd0;
            reg_count_reg  <= 7'd1;
            timeout_reg    <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS:  slave_addr_reg <= cfg_data[7:0];
                CFG_REQUEST_MODE:   req_mode_reg   <= cfg_data[0];
                CFG_FIRST_REGISTER: first_reg_reg  <= cfg_data;
                CFG_REGISTER_COUNT: reg_count_reg  <= cfg_data[6:0];
                CFG_TIMEOUT_MS:     timeout_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_kind_reg <= kind_t'(s_kind);
            in_byte_reg <= s_rx_byte;
            in_end_reg  <= s_frame_end;
        end
    end

    // shared byte-path values
    assign p            = byte_cnt_reg;
    assign frame_len    = {1'b0, p} + 10'd1;
    assign min_read_len = 10'd5 + {2'b00, reg_count_reg, 1'b0};
    assign crc_upd      = (p >= 9'd2) ? crc_feed(crc_reg, dly1_reg) : crc_reg;
    assign p_minus4     = p - 9'd4;
    assign word_idx     = p_minus4[8:1];
    assign opcode       = req_mode_reg ? OP_WRITE : OP_READ;

    // header bytes including the one arriving now
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            hdr_next[k] = (p == 9'(k)) ? in_byte_reg : hdr_reg[k];
        end
    end

    assign too_long_next = too_long_reg || (p >= MAX_FRAME_BYTES);

    // frame verdict at the final byte
    always_comb begin
        verdict      = ST_PROCESSED;
        verdict_code = 8'd0;
        if (too_long_next) begin
            verdict = ST_CORRUPTED;
        end else if (hdr_next[0] != slave_addr_reg) begin
            verdict = ST_CORRUPTED;
        end else if (frame_len < 10'd4) begin
            verdict = ST_CORRUPTED;
        end else if (in_byte_reg != crc_upd[15:8] || dly0_reg != crc_upd[7:0]) begin
            verdict = ST_CORRUPTED;
        end else if (hdr_next[1][6:0] != opcode) begin
            verdict = ST_CORRUPTED;
        end else if (hdr_next[1][7]) begin
            if (frame_len < 10'd5) begin
                verdict = ST_CORRUPTED;
            end else begin
                verdict      = ST_EXCEPTION;
                verdict_code = hdr_next[2];
            end
        end else if (!req_mode_reg) begin
            if ({1'b0, reg_count_reg} > MAX_READ_REGS) begin
                verdict = ST_CORRUPTED;
            end else if (frame_len < min_read_len
                         || hdr_next[2] != {reg_count_reg, 1'b0}) begin
                verdict = ST_CORRUPTED;
            end
        end else begin
            if (frame_len < 10'd8) begin
                verdict = ST_CORRUPTED;
            end else if (hdr_next[2] != first_reg_reg[15:8]
                         || hdr_next[3] != first_reg_reg[7:0]
                         || hdr_next[4] != 8'd0
                         || hdr_next[5] != {1'b0, reg_count_reg}) begin
                verdict = ST_CORRUPTED;
            end
        end
    end

    // item processing and result selection
    always_comb begin
        waiting_next  = waiting_reg;
        byte_cnt_next = byte_cnt_reg;
        crc_next      = crc_reg;
        dly0_next     = dly0_reg;
        dly1_next     = dly1_reg;
        elapsed_next  = elapsed_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        res_kind_next = res_kind_reg;
        res_idx_next  = res_idx_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        res_code_next = res_code_reg;

        if (advance) begin
            unique case (in_kind_reg)
                KIND_ARM: begin
                    waiting_next  = 1'b1;
                    elapsed_next  = 17'd0;
                    byte_cnt_next = 9'd0;
                    crc_next      = CRC_INIT;
                    dly0_next     = 8'd0;
                    dly1_next     = 8'd0;
                end
                KIND_ERR: begin
                    if (waiting_reg) begin
                        waiting_next  = 1'b0;
                        m_valid_next  = 1'b1;
                        res_kind_next = RES_STATUS;
                        res_idx_next  = 7'd0;
                        res_val_next  = 16'd0;
                        res_st_next   = ST_CORRUPTED;
                        res_code_next = 8'd0;
                    end
                end
                KIND_TICK: begin
                    if (waiting_reg) begin
                        elapsed_next = (elapsed_reg != ELAPSED_MAX)
                                       ? elapsed_reg + 17'd1 : elapsed_reg;
                        if (elapsed_next > {1'b0, timeout_reg}) begin
                            waiting_next  = 1'b0;
                            m_valid_next  = 1'b1;
                            res_kind_next = RES_STATUS;
                            res_idx_next  = 7'd0;
                            res_val_next  = 16'd0;
                            res_st_next   = ST_TIMEOUT;
                            res_code_next = 8'd0;
                        end
                    end
                end
                KIND_BYTE: begin
                    if (waiting_reg) begin
                        crc_next      = crc_upd;
                        byte_cnt_next = (p != BYTE_CNT_MAX) ? p + 9'd1 : p;
                        if (in_end_reg) begin
                            waiting_next  = 1'b0;
                            m_valid_next  = 1'b1;
                            res_kind_next = RES_STATUS;
                            res_idx_next  = 7'd0;
                            res_val_next  = 16'd0;
                            res_st_next   = verdict;
                            res_code_next = verdict_code;
                        end else begin
                            // provisional register word on every second data byte
                            if (!req_mode_reg && !too_long_next && p >= 9'd4
                                && !p[0]
                                && word_idx < {1'b0, reg_count_reg}
                                && word_idx < MAX_READ_REGS
                                && {1'b0, reg_count_reg} <= MAX_READ_REGS) begin
                                m_valid_next  = 1'b1;
                                res_kind_next = RES_WORD;
                                res_idx_next  = word_idx[6:0];
                                res_val_next  = {dly0_reg, in_byte_reg};
                                res_st_next   = ST_PROCESSED;
                                res_code_next = 8'd0;
                            end
                            dly1_next = dly0_reg;
                            dly0_next = in_byte_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // frame state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg  <= 1'b0;
            byte_cnt_reg <= 9'd0;
            crc_reg      <= CRC_INIT;
            dly0_reg     <= 8'd0;
            dly1_reg     <= 8'd0;
            elapsed_reg  <= 17'd0;
            too_long_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            waiting_reg  <= waiting_next;
            byte_cnt_reg <= byte_cnt_next;
            crc_reg      <= crc_next;
            dly0_reg     <= dly0_next;
            dly1_reg     <= dly1_next;
            elapsed_reg  <= elapsed_next;
            m_valid_reg  <= m_valid_next;
            if (advance && in_kind_reg == KIND_ARM) begin
                too_long_reg <= 1'b0;
            end else if (advance && in_kind_reg == KIND_BYTE && waiting_reg) begin
                too_long_reg <= too_long_next;
            end
        end
        res_kind_reg <= res_kind_next;
        res_idx_reg  <= res_idx_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        res_code_reg <= res_code_next;
        // header capture, first six bytes of the frame
        if (advance && in_kind_reg == KIND_BYTE && waiting_reg) begin
            for (int k = 0; k < 6; k++) begin
                hdr_reg[k] <= hdr_next[k];
            end
        end
    end

endmodule
